FILE: hdl/sm3_hash_engine_macros.svh
// Assertion macros for the SM3 hash engine.
`ifndef SM3_HASH_ENGINE_MACROS_SVH
`define SM3_HASH_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/sm3_pkg.sv
// Shared types, constants and functions of the SM3 hash engine.
`timescale 1ns / 1ps
package sm3_pkg;
   localparam logic [31:0] T_LOW  = 32'h79CC4519;
   localparam logic [31:0] T_HIGH = 32'h7A879D8A;
   localparam logic [255:0] IV = {32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                                  32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};
   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_COMP, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      FILL_DATA, FILL_PAD, FILL_ZERO, FILL_LEN
   } fill_type;

   // Controller to datapath.
   typedef struct packed {
      logic     wr;        // write one byte into the block
      fill_type fill;
      logic     cnt_inc;
      logic     comp_start;
      logic     round;     // advance one round
      logic     finish;    // fold working state into chaining value
      logic     clear;     // restart for next message
      logic     out_shift;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [5:0] pos;
      logic       round_last;
   } status_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] t;
      t = {x, x} << n;
      return t[63:32];
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction
endpackage

FILE: hdl/sm3_ctrl.sv
// Controller state machine of the SM3 hash engine.
`timescale 1ns / 1ps
module sm3_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                in_present,
   input  logic                in_end,
   input  logic                rsp_busy,
   output logic                rsp_load,
   input  sm3_pkg::status_type status,
   output sm3_pkg::cmd_type    cmd
);
   sm3_pkg::state_type state_ff, state_in;
   logic               final_ff, final_in;   // current compression is the message's last
   logic               end_ff, end_in;       // message end is pending
   logic               padded_ff, padded_in; // the 0x80 byte has been written
   logic               lenblk_ff, lenblk_in; // current block carries the length
   logic [2:0]         ocnt_ff, ocnt_in;
   logic               acc;

   assign acc = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sm3_pkg::ST_IDLE;
         final_ff  <= 1'b0;
         end_ff    <= 1'b0;
         padded_ff <= 1'b0;
         lenblk_ff <= 1'b0;
         ocnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         final_ff  <= final_in;
         end_ff    <= end_in;
         padded_ff <= padded_in;
         lenblk_ff <= lenblk_in;
         ocnt_ff   <= ocnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      final_in   = final_ff;
      end_in     = end_ff;
      padded_in  = padded_ff;
      lenblk_in  = lenblk_ff;
      ocnt_in    = ocnt_ff;
      cmd        = '0;
      cmd.fill   = sm3_pkg::FILL_DATA;
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         sm3_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (acc) begin
               if (in_present) begin
                  cmd.wr      = 1'b1;
                  cmd.cnt_inc = 1'b1;
               end
               final_in  = 1'b0;
               end_in    = in_end;
               padded_in = 1'b0;
               lenblk_in = 1'b0;
               if (in_present && status.pos == 6'd63) begin
                  // An ending word that fills a block pads after that block.
                  cmd.comp_start = 1'b1;
                  state_in = sm3_pkg::ST_COMP;
               end else if (in_end) begin
                  state_in = sm3_pkg::ST_PAD;
               end
            end
         end
         sm3_pkg::ST_PAD: begin
            // Writes one padding byte a cycle at the current position.
            cmd.wr = 1'b1;
            if (!padded_ff) begin
               cmd.fill  = sm3_pkg::FILL_PAD;
               padded_in = 1'b1;
               if (status.pos < 6'd56) lenblk_in = 1'b1;
            end else if (lenblk_ff && status.pos > 6'd55) begin
               cmd.fill = sm3_pkg::FILL_LEN;
            end else begin
               cmd.fill = sm3_pkg::FILL_ZERO;
            end
            if (status.pos == 6'd63) begin
               cmd.comp_start = 1'b1;
               final_in = padded_ff && lenblk_ff;
               state_in = sm3_pkg::ST_COMP;
            end
         end
         sm3_pkg::ST_COMP: begin
            cmd.round = 1'b1;
            if (status.round_last) begin
               cmd.finish = 1'b1;
               if (final_ff) begin
                  ocnt_in  = '0;
                  state_in = sm3_pkg::ST_OUT;
               end else if (end_ff) begin
                  lenblk_in = padded_ff;
                  state_in  = sm3_pkg::ST_PAD;
               end else begin
                  state_in = sm3_pkg::ST_IDLE;
               end
            end
         end
         sm3_pkg::ST_OUT: begin
            if (!rsp_busy) begin
               rsp_load      = 1'b1;
               cmd.out_shift = 1'b1;
               ocnt_in       = ocnt_ff + 3'd1;
               if (ocnt_ff == 3'd7) begin
                  cmd.clear = 1'b1;
                  state_in  = sm3_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sm3_pkg::ST_IDLE;
      endcase
   end
endmodule

FILE: hdl/sm3_datapath.sv
// Datapath of the SM3 hash engine: message shift register, counter and round logic.
`timescale 1ns / 1ps
module sm3_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          in_byte,
   input  sm3_pkg::cmd_type    cmd,
   output sm3_pkg::status_type status,
   output logic [31:0]         out_word
);
   logic [60:0]       cnt_ff, cnt_in;
   logic [5:0]        pos_ff, pos_in;
   logic [31:0]       w_ff [16];
   logic [31:0]       cv_ff [8];
   logic [31:0]       a_ff [8];
   logic [5:0]        rnd_ff;
   logic [63:0]       bits;
   logic [7:0]        wbyte;
   logic [31:0]       tj, a12, ss1, ss2, ff, gg, tt1, tt2, wn;

   assign bits = {cnt_ff, 3'b000};
   assign status.pos = pos_ff;
   assign status.round_last = (rnd_ff == 6'd63);
   assign out_word = cv_ff[0];

   always_comb begin
      case (cmd.fill)
         sm3_pkg::FILL_DATA: wbyte = in_byte;
         sm3_pkg::FILL_PAD:  wbyte = sm3_pkg::PAD_BYTE;
         sm3_pkg::FILL_ZERO: wbyte = 8'h00;
         sm3_pkg::FILL_LEN:  wbyte = bits[{~pos_ff[2:0], 3'b000} +: 8];
         default:            wbyte = 8'h00;
      endcase
      cnt_in = cnt_ff + 61'(cmd.cnt_inc);
      pos_in = cmd.wr ? pos_ff + 6'd1 : pos_ff;
   end

   always_comb begin
      tj  = (rnd_ff < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
      a12 = sm3_pkg::rotl(a_ff[0], 5'd12);
      ss1 = sm3_pkg::rotl(a12 + a_ff[4] + sm3_pkg::rotl(tj, rnd_ff[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      if (rnd_ff < 6'd16) begin
         ff = a_ff[0] ^ a_ff[1] ^ a_ff[2];
         gg = a_ff[4] ^ a_ff[5] ^ a_ff[6];
      end else begin
         ff = (a_ff[0] & a_ff[1]) | (a_ff[0] & a_ff[2]) | (a_ff[1] & a_ff[2]);
         gg = (a_ff[4] & a_ff[5]) | (~a_ff[4] & a_ff[6]);
      end
      tt1 = ff + a_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = gg + a_ff[7] + ss1 + w_ff[0];
      wn  = sm3_pkg::p1(w_ff[0] ^ w_ff[7] ^ sm3_pkg::rotl(w_ff[13], 5'd15))
            ^ sm3_pkg::rotl(w_ff[3], 5'd7) ^ w_ff[10];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
         rnd_ff <= '0;
         for (int i = 0; i < 8; i++) cv_ff[i] <= sm3_pkg::IV[32 * (7 - i) +: 32];
      end else begin
         cnt_ff <= cmd.clear ? '0 : cnt_in;
         pos_ff <= cmd.clear ? '0 : pos_in;
         // Bytes enter at the low byte of w_ff[15] and shift down, so a full block holds its first word in w_ff[0].
         if (cmd.wr) begin
            for (int i = 0; i < 15; i++) w_ff[i] <= {w_ff[i][23:0], w_ff[i + 1][31:24]};
            w_ff[15] <= {w_ff[15][23:0], wbyte};
         end else if (cmd.round) begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
            w_ff[15] <= wn;
         end
         if (cmd.comp_start) begin
            for (int i = 0; i < 8; i++) a_ff[i] <= cv_ff[i];
            rnd_ff <= '0;
         end else if (cmd.round) begin
            a_ff[0] <= tt1;
            a_ff[1] <= a_ff[0];
            a_ff[2] <= sm3_pkg::rotl(a_ff[1], 5'd9);
            a_ff[3] <= a_ff[2];
            a_ff[4] <= sm3_pkg::p0(tt2);
            a_ff[5] <= a_ff[4];
            a_ff[6] <= sm3_pkg::rotl(a_ff[5], 5'd19);
            a_ff[7] <= a_ff[6];
            rnd_ff  <= rnd_ff + 6'd1;
            if (cmd.finish) begin
               cv_ff[0] <= cv_ff[0] ^ tt1;
               cv_ff[1] <= cv_ff[1] ^ a_ff[0];
               cv_ff[2] <= cv_ff[2] ^ sm3_pkg::rotl(a_ff[1], 5'd9);
               cv_ff[3] <= cv_ff[3] ^ a_ff[2];
               cv_ff[4] <= cv_ff[4] ^ sm3_pkg::p0(tt2);
               cv_ff[5] <= cv_ff[5] ^ a_ff[4];
               cv_ff[6] <= cv_ff[6] ^ sm3_pkg::rotl(a_ff[5], 5'd19);
               cv_ff[7] <= cv_ff[7] ^ a_ff[6];
            end
         end
         if (cmd.out_shift) begin
            for (int i = 0; i < 7; i++) cv_ff[i] <= cv_ff[i + 1];
            cv_ff[7] <= cv_ff[0];
         end
         if (cmd.clear) begin
            for (int i = 0; i < 8; i++) cv_ff[i] <= sm3_pkg::IV[32 * (7 - i) +: 32];
         end
      end
   end
endmodule

FILE: hdl/sm3_hash_engine.sv
// Top level of the SM3 hash engine.
`timescale 1ns / 1ps
`include "sm3_hash_engine_macros.svh"
// Takes one byte word per cycle while a block fills; the word that completes a 64-byte block
// starts the rounds in the single shared round unit, during which no word is taken.
// Message end adds the padding bytes (with an extra block when the length does not fit),
// one or two compressions, and eight digest words, most significant first, through an
// output register.
module sm3_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // msg_byte[7:0]
   input  logic        req_tuser,  // byte_present
   input  logic        req_tlast,  // message_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // digest_word[31:0], word_index[34:32]
   output logic        rsp_tlast   // last_word
);
   sm3_pkg::cmd_type    cmd;
   sm3_pkg::status_type status;
   logic [31:0]         out_word;
   logic                rsp_load;
   logic                rsp_busy;
   logic                rvalid_ff;
   logic [2:0]          ridx_ff;
   logic [31:0]         rword_ff;

   assign rsp_busy = rvalid_ff && !rsp_tready;

   sm3_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .in_present(req_tuser), .in_end(req_tlast),
      .rsp_busy(rsp_busy), .rsp_load(rsp_load), .status(status), .cmd(cmd)
   );

   sm3_datapath u_dp (
      .clock(clock), .reset(reset), .in_byte(req_tdata), .cmd(cmd),
      .status(status), .out_word(out_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
         ridx_ff   <= '0;
      end else begin
         if (rsp_load) begin
            rvalid_ff <= 1'b1;
            ridx_ff   <= ridx_ff + 3'd1;
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
      end
      if (rsp_load) rword_ff <= out_word;
   end

   logic [2:0] shown_idx;
   assign shown_idx  = ridx_ff - 3'd1;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {5'd0, shown_idx, rword_ff};
   assign rsp_tlast  = (shown_idx == 3'd7);

   `SM3_ASSERT_IMPL(a_no_load_busy, clock, reset, rsp_busy, !rsp_load, "load over held word")
   `SM3_ASSERT_NEXT(a_load_valid, clock, reset, rsp_load, rsp_tvalid, "loaded word not shown")
   `SM3_ASSERT_IMPL(a_ready_excl, clock, reset, req_tready, !rsp_load, "input during output")
endmodule

FILE: bench/tb_sm3_hash_engine.sv
// Self-checking testbench for the SM3 hash engine: random byte streams against a behavioral hash.
`timescale 1ns / 1ps
class sm3_digest_board;
   logic [39:0] pending_words[$];
   logic        pending_last[$];
   int          mismatches;
   int          digest_words_seen;
   logic [31:0] chain[8];
   logic [7:0]  block_bytes[64];
   logic [60:0] byte_total;

   function new();
      mismatches = 0;
      digest_words_seen = 0;
      restart();
   endfunction

   function void restart();
      for (int i = 0; i < 8; i++) chain[i] = sm3_pkg::IV[255 - 32 * i -: 32];
      byte_total = '0;
   endfunction

   function logic [31:0] rol(logic [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
   endfunction

   function void compress();
      logic [31:0] w[68];
      logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2, x;
      for (int j = 0; j < 16; j++)
         w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
      for (int j = 16; j < 68; j++) begin
         x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
         w[j] = (x ^ rol(x, 15) ^ rol(x, 23)) ^ rol(w[j-13], 7) ^ w[j-6];
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int j = 0; j < 64; j++) begin
         tj = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
         a12 = rol(a, 12);
         ss1 = rol(a12 + e + rol(tj, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
         end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
         end
         tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + h + ss1 + w[j];
         d = c; c = rol(b, 9); b = a; a = tt1;
         h = g; g = rol(f, 19); f = e;
         e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      end
      chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
      chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
   endfunction

   function void note_word(logic [7:0] data, logic present, logic done);
      logic [63:0] bit_len;
      int pos;
      if (present) begin
         block_bytes[byte_total[5:0]] = data;
         byte_total = byte_total + 1'b1;
         if (byte_total[5:0] == 0) compress();
      end
      if (!done) return;
      bit_len = {byte_total, 3'b000};
      pos = byte_total[5:0];
      block_bytes[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
         while (pos < 64) block_bytes[pos++] = 8'h00;
         compress();
         pos = 0;
      end
      while (pos < 56) block_bytes[pos++] = 8'h00;
      for (int k = 0; k < 8; k++) block_bytes[56 + k] = bit_len[63 - 8 * k -: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
         pending_words.push_back({5'd0, 3'(k), chain[k]});
         pending_last.push_back(k == 7);
      end
      restart();
   endfunction

   function void check_word(logic [39:0] data, logic last);
      logic [39:0] want;
      logic        want_last;
      digest_words_seen++;
      if (pending_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected digest word %h last %b", data, last);
         return;
      end
      want = pending_words.pop_front();
      want_last = pending_last.pop_front();
      if (data[31:0] !== want[31:0] || data[34:32] !== want[34:32] || last !== want_last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("digest mismatch: expected word %h index %0d last %b, got %h %0d %b",
               want[31:0], want[34:32], want_last, data[31:0], data[34:32], last);
      end
   endfunction
endclass

module tb_sm3_hash_engine;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   sm3_digest_board board = new();
   int          words_sent = 0;
   int          messages = 0;
   int          rsp_quiet = 0;

   sm3_hash_engine uut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata, rsp_tlast);
      if (rsp_quiet > 0) begin
         rsp_tready <= 1'b0;
         rsp_quiet <= rsp_quiet - 1;
      end else if (rsp_tvalid && rsp_tready) begin
         if ($urandom_range(3) == 0) begin
            rsp_quiet <= $urandom_range(13);
            rsp_tready <= 1'b0;
         end
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_word(logic [7:0] data, logic present, logic done, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= present;
      req_tlast <= done;
      do @(posedge clock); while (!req_tready);
      board.note_word(data, present, done);
      words_sent++;
      if (done) messages++;
   endtask

   function automatic int pick_gap(bit busy);
      if (busy) return 0;
      return $urandom_range(13);
   endfunction

   function automatic int cap(int n, int left);
      return (n < left) ? n : left;
   endfunction

   task automatic send_message(int len, bit burst, int fill);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0, pick_gap(burst));
         send_word(fill >= 0 ? 8'(fill) : 8'($urandom), 1'b1, i == len - 1, pick_gap(burst));
      end
   endtask

   initial begin
      int left;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_word(8'hFF, 1'b0, 1'b1, 0);
      send_word(8'h00, 1'b1, 1'b1, 0);
      send_word(8'hFF, 1'b1, 1'b1, 1);
      send_word(8'h61, 1'b1, 1'b0, 0);
      send_word(8'h62, 1'b1, 1'b0, 0);
      send_word(8'h00, 1'b0, 1'b0, 3);
      send_word(8'h63, 1'b1, 1'b0, 0);
      send_word(8'hAA, 1'b0, 1'b1, 0);
      send_message(8, 1'b1, 8'h55);
      send_message(7, 1'b0, -1);
      while (words_sent < 470) begin
         left = 470 - words_sent;
         case ($urandom_range(5))
            0: send_message(cap($urandom_range(1, 8), left), 1'($urandom_range(1)), -1);
            1: send_message(cap($urandom_range(55, 57), left), 1'($urandom_range(1)), -1);
            2: send_message(cap($urandom_range(63, 65), left), 1'($urandom_range(1)), -1);
            3: send_message(cap($urandom_range(100, 130), left), 1'b1, -1);
            4: send_word(8'($urandom), 1'b0, 1'b1, pick_gap(1'b0));
            default: send_message(cap($urandom_range(9, 40), left), 1'($urandom_range(1)), -1);
         endcase
      end
      req_tvalid <= 1'b0;
      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d words in %0d messages with random gaps and stalls.", words_sent,
         messages);
      $display("Checked %0d digest words; %0d mismatches.", board.digest_words_seen,
         board.mismatches);
      if (board.mismatches == 0 && board.pending_words.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/sm3_pkg.sv
hdl/sm3_ctrl.sv
hdl/sm3_datapath.sv
hdl/sm3_hash_engine.sv
bench/tb_sm3_hash_engine.sv
